[design/generational_handle_allocator_defines.svh]
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define GHA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("handle allocator check failed");

// Check that cons holds in the cycle after ante.
`define GHA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("handle allocator check failed");

`endif

[design/gha_pkg.sv]
`timescale 1ns / 1ps

package gha_pkg;

  // Table geometry and limits
  localparam int MAX_SLOTS          = 1024;
  localparam int MAX_GENERATION     = 255;
  localparam int DEF_RECYCLE_TRIES  = 5;

  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int GEN_W = 8;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);

  typedef enum logic [1:0] {
    KIND_SPAWN   = 2'd0,
    KIND_KILL    = 2'd1,
    KIND_QUERY   = 2'd2,
    KIND_CLEANUP = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_STALE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SP_CHK,
    S_SP_IDX,
    S_SP_TEST,
    S_SP_NEW,
    S_KQ_RD,
    S_KQ_EVAL,
    S_CL_CHK,
    S_CL_GEN,
    S_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;       // capture request, clear result
    logic pop;         // pop free stack, read top entry
    logic gen_rd_pop;  // read generation of popped slot
    logic take;        // reuse popped slot
    logic tomb_pop;    // retire popped slot to tombstones
    logic new_slot;    // open a fresh slot
    logic full;        // report table full
    logic gen_rd_h;    // read generation of request handle
    logic kq_eval;     // evaluate kill or query
    logic cl_rd;       // read next tombstone
    logic cl_item;     // recycle tombstone just read
    logic cl_end;      // empty tombstone list
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic free_empty;
    logic tries_done;
    logic take_ok;
    logic slots_full;
    logic clean_done;
  } sts_t;

endpackage

[design/gha_ctrl.sv]
`timescale 1ns / 1ps
`include "generational_handle_allocator_defines.svh"

module gha_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [1:0]    in_kind,
  input  gha_pkg::sts_t sts,
  output gha_pkg::cmd_t cmd,
  output logic          busy,
  output logic          out_valid
);
  import gha_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          unique case (kind_t'(in_kind)) inside
            KIND_SPAWN:             state_nxt = S_SP_CHK;
            KIND_KILL, KIND_QUERY:  state_nxt = S_KQ_RD;
            default:                state_nxt = S_CL_CHK;
          endcase
        end
      end
      S_SP_CHK: begin
        if (!sts.free_empty && !sts.tries_done) begin
          cmd.pop   = 1'b1;
          state_nxt = S_SP_IDX;
        end else begin
          state_nxt = S_SP_NEW;
        end
      end
      S_SP_IDX: begin
        cmd.gen_rd_pop = 1'b1;
        state_nxt      = S_SP_TEST;
      end
      S_SP_TEST: begin
        if (sts.take_ok) begin
          cmd.take  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.tomb_pop = 1'b1;
          state_nxt    = S_SP_CHK;
        end
      end
      S_SP_NEW: begin
        if (sts.slots_full) begin
          cmd.full = 1'b1;
        end else begin
          cmd.new_slot = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_KQ_RD: begin
        cmd.gen_rd_h = 1'b1;
        state_nxt    = S_KQ_EVAL;
      end
      S_KQ_EVAL: begin
        cmd.kq_eval = 1'b1;
        state_nxt   = S_DONE;
      end
      S_CL_CHK: begin
        if (sts.clean_done) begin
          cmd.cl_end = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          cmd.cl_rd = 1'b1;
          state_nxt = S_CL_GEN;
        end
      end
      S_CL_GEN: begin
        cmd.cl_item = 1'b1;
        state_nxt   = S_CL_CHK;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

  `GHA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `GHA_ASSERT_NEXT(a_strobe_then_idle, out_valid, !busy && !out_valid)
  `GHA_ASSERT_SAME(a_latch_only_idle, cmd.latch, !busy && start)

endmodule

[design/gha_datapath.sv]
`timescale 1ns / 1ps
`include "generational_handle_allocator_defines.svh"

module gha_datapath #(
  parameter int RECYCLE_TRIES = gha_pkg::DEF_RECYCLE_TRIES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gha_pkg::cmd_t        cmd,
  input  logic [1:0]           in_kind,
  input  logic [9:0]           in_handle_index,
  input  logic [7:0]           in_handle_generation,
  output gha_pkg::sts_t        sts,
  output logic [9:0]           out_index,
  output logic [7:0]           out_generation,
  output logic [1:0]           out_status,
  output logic [10:0]          out_cleaned_count
);
  import gha_pkg::*;

  localparam int TRY_W = $clog2(RECYCLE_TRIES + 1);

  // Stores
  logic [GEN_W-1:0] gen_mem   [MAX_SLOTS];
  logic [IDX_W-1:0] stack_mem [MAX_SLOTS];
  logic [IDX_W-1:0] tomb_mem  [MAX_SLOTS];

  // Control state
  logic [CNT_W-1:0] su_r, su_nxt;
  logic [CNT_W-1:0] fc_r, fc_nxt;
  logic [CNT_W-1:0] tc_r, tc_nxt;
  logic [CNT_W-1:0] ci_r, ci_nxt;
  logic [TRY_W-1:0] tries_r, tries_nxt;

  // Request and result registers
  kind_t            kind_r;
  logic [IDX_W-1:0] hidx_r;
  logic [GEN_W-1:0] hgen_r;
  logic [IDX_W-1:0] res_idx_r;
  logic [GEN_W-1:0] res_gen_r;
  status_t          res_st_r;
  logic [CNT_W-1:0] cleaned_r;

  // Memory read data
  logic [GEN_W-1:0] gen_q;
  logic [IDX_W-1:0] stack_q;
  logic [IDX_W-1:0] tomb_q;

  logic [CNT_W-1:0] fc_dec;
  logic             live, retire, is_kill, tomb_ok;
  logic             gen_we, free_push, tomb_push;
  logic [IDX_W-1:0] gen_waddr, gen_raddr, free_data, tomb_data;
  logic [GEN_W-1:0] gen_wdata;

  assign fc_dec  = fc_r - CNT_W'(1);
  assign is_kill = (kind_r == KIND_KILL);
  assign live    = ({1'b0, hidx_r} < su_r) && (gen_q == hgen_r);
  assign retire  = (gen_q >= GEN_W'(MAX_GENERATION - 1));
  assign tomb_ok = ({1'b0, tomb_q} < su_r);

  // Write and read port selection
  always_comb begin
    gen_we    = 1'b0;
    gen_waddr = hidx_r;
    gen_wdata = '0;
    free_push = 1'b0;
    free_data = hidx_r;
    tomb_push = 1'b0;
    tomb_data = hidx_r;
    if (cmd.new_slot) begin
      gen_we    = 1'b1;
      gen_waddr = su_r[IDX_W-1:0];
    end
    if (cmd.kq_eval && is_kill && live) begin
      gen_we = 1'b1;
      if (retire) begin
        gen_wdata = GEN_W'(MAX_GENERATION);
        tomb_push = 1'b1;
      end else begin
        gen_wdata = gen_q + GEN_W'(1);
        free_push = 1'b1;
      end
    end
    if (cmd.cl_item && tomb_ok) begin
      gen_we    = 1'b1;
      gen_waddr = tomb_q;
      free_push = 1'b1;
      free_data = tomb_q;
    end
    if (cmd.tomb_pop) begin
      tomb_push = 1'b1;
      tomb_data = stack_q;
    end
    gen_raddr = cmd.gen_rd_h ? hidx_r : stack_q;
  end

  // Generation table
  always_ff @(posedge clk) begin
    if (gen_we) begin
      gen_mem[gen_waddr] <= gen_wdata;
    end
    if (cmd.gen_rd_h || cmd.gen_rd_pop) begin
      gen_q <= gen_mem[gen_raddr];
    end
  end

  // Free stack
  always_ff @(posedge clk) begin
    if (free_push && (fc_r < CNT_W'(MAX_SLOTS))) begin
      stack_mem[fc_r[IDX_W-1:0]] <= free_data;
    end
    if (cmd.pop) begin
      stack_q <= stack_mem[fc_dec[IDX_W-1:0]];
    end
  end

  // Tombstone list
  always_ff @(posedge clk) begin
    if (tomb_push && (tc_r < CNT_W'(MAX_SLOTS))) begin
      tomb_mem[tc_r[IDX_W-1:0]] <= tomb_data;
    end
    if (cmd.cl_rd) begin
      tomb_q <= tomb_mem[ci_r[IDX_W-1:0]];
    end
  end

  // Counter updates
  always_comb begin
    su_nxt    = su_r;
    fc_nxt    = fc_r;
    tc_nxt    = tc_r;
    ci_nxt    = ci_r;
    tries_nxt = tries_r;
    if (cmd.latch) begin
      ci_nxt    = '0;
      tries_nxt = '0;
    end
    if (cmd.new_slot) begin
      su_nxt = su_r + CNT_W'(1);
    end
    if (cmd.pop) begin
      fc_nxt = fc_dec;
    end else if (free_push && (fc_r < CNT_W'(MAX_SLOTS))) begin
      fc_nxt = fc_r + CNT_W'(1);
    end
    if (cmd.cl_end) begin
      tc_nxt = '0;
    end else if (tomb_push && (tc_r < CNT_W'(MAX_SLOTS))) begin
      tc_nxt = tc_r + CNT_W'(1);
    end
    if (cmd.tomb_pop) begin
      tries_nxt = tries_r + TRY_W'(1);
    end
    if (cmd.cl_rd) begin
      ci_nxt = ci_r + CNT_W'(1);
    end
  end

  // Counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      su_r    <= '0;
      fc_r    <= '0;
      tc_r    <= '0;
      ci_r    <= '0;
      tries_r <= '0;
    end else begin
      su_r    <= su_nxt;
      fc_r    <= fc_nxt;
      tc_r    <= tc_nxt;
      ci_r    <= ci_nxt;
      tries_r <= tries_nxt;
    end
  end

  // Request capture and result build
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r    <= kind_t'(in_kind);
      hidx_r    <= in_handle_index;
      hgen_r    <= in_handle_generation;
      res_idx_r <= '0;
      res_gen_r <= '0;
      res_st_r  <= ST_OK;
      cleaned_r <= '0;
    end
    if (cmd.take) begin
      res_idx_r <= stack_q;
      res_gen_r <= gen_q;
    end
    if (cmd.new_slot) begin
      res_idx_r <= su_r[IDX_W-1:0];
    end
    if (cmd.full) begin
      res_st_r <= ST_FULL;
    end
    if (cmd.kq_eval) begin
      res_st_r <= live ? ST_OK : ST_STALE;
    end
    if (cmd.cl_item && tomb_ok) begin
      cleaned_r <= cleaned_r + CNT_W'(1);
    end
  end

  assign sts.free_empty = (fc_r == '0);
  assign sts.tries_done = (tries_r == TRY_W'(RECYCLE_TRIES));
  assign sts.take_ok    = ({1'b0, stack_q} < su_r) && (gen_q < GEN_W'(MAX_GENERATION));
  assign sts.slots_full = (su_r == CNT_W'(MAX_SLOTS));
  assign sts.clean_done = (ci_r == tc_r);

  assign out_index         = res_idx_r;
  assign out_generation    = res_gen_r;
  assign out_status        = res_st_r;
  assign out_cleaned_count = cleaned_r;

  `GHA_ASSERT_SAME(a_free_bound, 1'b1, fc_r <= CNT_W'(MAX_SLOTS))
  `GHA_ASSERT_SAME(a_slots_bound, 1'b1, su_r <= CNT_W'(MAX_SLOTS))
  `GHA_ASSERT_NEXT(a_tomb_emptied, cmd.cl_end, tc_r == '0)

endmodule

[design/generational_handle_allocator.sv]
`timescale 1ns / 1ps
// Generational handle allocator.
// Request channel: drive in_kind, in_handle_index and in_handle_generation with
// start; the request is taken at a clock edge where start is high and busy low.
// Result channel: out_valid is high for exactly one cycle with out_index,
// out_generation, out_status and out_cleaned_count; the receiver must take it.
// Steps from the accepting edge to the result cycle:
//   kill or query: one generation table read, then one evaluate.
//   spawn: stack read, table read and test per popped slot, up to RECYCLE_TRIES
//     slots, then a check and a fresh slot or full report if none is reused.
//   cleanup: list read and recycle per tombstone, then an end check.
// busy falls in the cycle after the result, and a new request is taken then,
// so a request is done before the next is taken. The rate is set by the
// single-ported, registered reads of the generation table, free stack and
// tombstone list, which the controller walks one access at a time.
// Reset (synchronous, rst_n low) empties the free stack and tombstone list
// and closes all slots; the stores need no clearing pass.
module generational_handle_allocator #(
  parameter int RECYCLE_TRIES = gha_pkg::DEF_RECYCLE_TRIES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [9:0]  in_handle_index,
  input  logic [7:0]  in_handle_generation,
  output logic        out_valid,
  output logic [9:0]  out_index,
  output logic [7:0]  out_generation,
  output logic [1:0]  out_status,
  output logic [10:0] out_cleaned_count
);
  import gha_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence each request
  gha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_kind   (in_kind),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Hold stores, counters and result
  gha_datapath #(
    .RECYCLE_TRIES (RECYCLE_TRIES)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .in_kind              (in_kind),
    .in_handle_index      (in_handle_index),
    .in_handle_generation (in_handle_generation),
    .sts                  (sts),
    .out_index            (out_index),
    .out_generation       (out_generation),
    .out_status           (out_status),
    .out_cleaned_count    (out_cleaned_count)
  );

endmodule
